FILE: design/swsim_pkg.sv
// Shared types, constants and helper functions of the string wave simulator.
package swsim_pkg;

    localparam int NUM_MASSES_DEF = 256;
    localparam int SINE_DEPTH_DEF = 1024;
    localparam int DISP_W         = 32;
    localparam int SAMPLE_W       = 24;
    localparam int CFG_IDX_W      = 3;
    localparam int PROD_W         = 66;
    localparam int QUO_W          = 21;

    localparam logic [QUO_W-1:0] PLUCK_PEAK  = 21'd1073742;
    localparam logic [32:0]      GAIN_30DB   = 33'd2072431;
    localparam longint unsigned  HALF_PI_Q30 = 64'd1686629713;

    // Command codes
    localparam logic [1:0] OP_STEP  = 2'd0;
    localparam logic [1:0] OP_PLUCK = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DAMP_SCALE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREV_DAMP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUPLING   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VIB_EN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VIB_SHAPE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VIB_LEVEL  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INC  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBSTEPS   = 3'd7;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CLR   = 8'b0000_0010,
        S_VIB   = 8'b0000_0100,
        S_LOAD  = 8'b0000_1000,
        S_MASS  = 8'b0001_0000,
        S_OUT   = 8'b0010_0000,
        S_DIV   = 8'b0100_0000,
        S_PLUCK = 8'b1000_0000
    } state_t;

    // Saturate a wide product-domain value to the signed displacement range
    function automatic logic signed [DISP_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = PROD_W'(64'sd2147483647);
        lo = PROD_W'(-64'sd2147483648);
        if (v > hi)
        begin
            sat32 = 32'sh7FFF_FFFF;
        end
        else if (v < lo)
        begin
            sat32 = 32'sh8000_0000;
        end
        else
        begin
            sat32 = v[DISP_W-1:0];
        end
    endfunction

    // Saturate to the signed 24-bit sample range
    function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = PROD_W'(64'sd8388607);
        lo = PROD_W'(-64'sd8388608);
        if (v > hi)
        begin
            sat24 = 24'sh7F_FFFF;
        end
        else if (v < lo)
        begin
            sat24 = 24'sh80_0000;
        end
        else
        begin
            sat24 = v[SAMPLE_W-1:0];
        end
    endfunction

    // Next bank in rotation order, modulo three
    function automatic logic [1:0] bank_inc(input logic [1:0] b);
        case (b)
            2'd0:    bank_inc = 2'd1;
            2'd1:    bank_inc = 2'd2;
            default: bank_inc = 2'd0;
        endcase
    endfunction

    // Previous bank in rotation order, modulo three
    function automatic logic [1:0] bank_dec(input logic [1:0] b);
        case (b)
            2'd1:    bank_dec = 2'd0;
            2'd2:    bank_dec = 2'd1;
            default: bank_dec = 2'd2;
        endcase
    endfunction

endpackage

FILE: design/swsim_bank.sv
// One displacement bank: single write port, registered read port.
module swsim_bank #(
    parameter int DEPTH = swsim_pkg::NUM_MASSES_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [AW-1:0]                 waddr,
    input  logic [swsim_pkg::DISP_W-1:0]  wdata,
    input  logic [AW-1:0]                 raddr,
    output logic [swsim_pkg::DISP_W-1:0]  rdata
);
    import swsim_pkg::*;

    logic [DISP_W-1:0] mem [DEPTH];

    // Write and read the storage array
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/string_wave_simulator_unit.sv
// Top level of the damped string wave simulator with vibrator and two pickups.
// Commands enter on start while busy is low. A step runs the vibrator, primes
// the neighbor window, updates the interior masses (one shared 33x33
// multiplier used five times per mass) and, when it emits, scales the two
// pickups. A pluck runs the divider for both segment lengths, then writes the
// NUM_MASSES-2 interior masses; a clear writes all NUM_MASSES masses, and
// after reset the same clearing pass runs with busy high. Samples appear for
// one cycle on sample_strobe and must be taken then: the receiver cannot
// stall. Configuration is always ready and must only be written while busy
// is low.
module string_wave_simulator_unit #(
    parameter int NUM_MASSES       = swsim_pkg::NUM_MASSES_DEF,
    parameter int SINE_TABLE_DEPTH = swsim_pkg::SINE_DEPTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [1:0]                             opcode,
    input  logic [7:0]                             pluck_position,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [swsim_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [31:0]                            cfg_data,
    output logic                                   sample_strobe,
    output logic signed [swsim_pkg::SAMPLE_W-1:0]  left_sample,
    output logic signed [swsim_pkg::SAMPLE_W-1:0]  right_sample
);
    import swsim_pkg::*;

    localparam int IW = $clog2(NUM_MASSES);
    localparam int SW = $clog2(SINE_TABLE_DEPTH);
    localparam logic [IW-1:0] LAST_INT   = IW'(NUM_MASSES - 2);
    localparam logic [IW-1:0] LAST_MASS  = IW'(NUM_MASSES - 1);
    localparam logic [IW-1:0] LEFT_PICK  = IW'(NUM_MASSES / 13);
    localparam logic [IW-1:0] RIGHT_PICK = IW'(NUM_MASSES / 5);
    localparam logic [IW-1:0] MASSES_W   = IW'(NUM_MASSES);

    typedef logic signed [DISP_W-1:0] rom_t [SINE_TABLE_DEPTH];

    // Build the quarter-wave-folded Taylor sine table at elaboration
    function automatic rom_t build_rom();
        rom_t tab;
        longint unsigned ph;
        longint unsigned r;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint sum;
        int q;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++)
        begin
            ph = (longint'(k) << 32) / SINE_TABLE_DEPTH;
            q = int'((ph >> 30) & 64'd3);
            r = ph & 64'h3FFF_FFFF;
            if (q[0])
            begin
                r = 64'd1073741824 - r;
            end
            x = (r * HALF_PI_Q30) >> 30;
            x2 = (x * x) >> 30;
            t = x;
            sum = longint'(x);
            for (int n = 1; n <= 8; n++)
            begin
                t = (t * x2) >> 30;
                // Divide by (2n)(2n+1) for the next Taylor term
                case (n)
                    1:       t = t / 64'd6;
                    2:       t = t / 64'd20;
                    3:       t = t / 64'd42;
                    4:       t = t / 64'd72;
                    5:       t = t / 64'd110;
                    6:       t = t / 64'd156;
                    7:       t = t / 64'd210;
                    default: t = t / 64'd272;
                endcase
                sum = n[0] ? sum - longint'(t) : sum + longint'(t);
            end
            if (sum < 0)
            begin
                sum = 0;
            end
            if (sum > 64'sd1073741824)
            begin
                sum = 64'sd1073741824;
            end
            tab[k] = DISP_W'(q >= 2 ? -sum : sum);
        end
        return tab;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    // Control state
    state_t state_reg, state_next;
    logic [3:0]  ph_reg, ph_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [1:0]  rot_reg, rot_next;
    logic [31:0] phase_reg, phase_next;
    logic [5:0]  count_reg, count_next;
    logic        emit_reg, emit_next;
    logic        strobe_reg, strobe_next;
    logic        dsel_reg, dsel_next;
    logic [4:0]  bit_reg, bit_next;

    // Configuration registers
    logic [30:0]        c1_reg, c3_reg;
    logic signed [31:0] c2_reg, level_reg;
    logic               vib_en_reg, vib_shape_reg;
    logic [31:0]        inc_reg;
    logic [6:0]         subs_reg;

    // Datapath registers
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [DISP_W-1:0] ym1_reg, yc_reg, yp_reg, yoo_reg, sine_reg;
    logic signed [34:0] lap_reg, acc_reg;
    logic [31:0]        s_reg;
    logic signed [37:0] inner_reg;
    logic signed [DISP_W-1:0] left_y_reg, right_y_reg;
    logic signed [SAMPLE_W-1:0] left_out_reg, right_out_reg;
    logic [IW-1:0]      p_reg, rem_reg, ra_reg, rb_reg, r_reg;
    logic [QUO_W-1:0]   quo_reg, qa_reg, qb_reg, q_reg;

    // Bank interface
    logic [2:0]          wr_en;
    logic [IW-1:0]       wr_addr, ra_o, ra_oo;
    logic [DISP_W-1:0]   wr_data;
    logic [DISP_W-1:0]   rd [3];
    logic [1:0]          yb, ob, oob;
    logic signed [DISP_W-1:0] rd_o, rd_oo;

    // Shared multiplier operands
    logic signed [32:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] prod_full;

    logic signed [DISP_W-1:0] vib_val, res_val, pluck_val;
    logic        accept;
    logic [6:0]  lim, cnt1;
    logic [IW:0] rem2, rsum;
    logic [IW-1:0] dv, dvc, r0c, rn;
    logic        ge, carry, seg;
    logic [QUO_W-1:0] q0c, qn;
    logic [IW-1:0] p_sat;
    logic        shift_en;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign sample_strobe = strobe_reg;
    assign left_sample   = left_out_reg;
    assign right_sample  = right_out_reg;

    // Bank roles for this step
    assign yb  = rot_reg;
    assign ob  = bank_inc(rot_reg);
    assign oob = bank_dec(rot_reg);

    // Instantiate the three displacement banks
    for (genvar b = 0; b < 3; b++)
    begin : g_bank
        swsim_bank #(.DEPTH(NUM_MASSES)) u_bank (
            .clk   (clk),
            .we    (wr_en[b]),
            .waddr (wr_addr),
            .wdata (wr_data),
            .raddr ((ob == 2'(b)) ? ra_o : ra_oo),
            .rdata (rd[b])
        );
    end

    // Select read data by role
    always_comb
    begin
        case (ob)
            2'd0:    rd_o = rd[0];
            2'd1:    rd_o = rd[1];
            default: rd_o = rd[2];
        endcase
        case (oob)
            2'd0:    rd_oo = rd[0];
            2'd1:    rd_oo = rd[1];
            default: rd_oo = rd[2];
        endcase
    end

    // Clamp pluck position and substep limit
    always_comb
    begin
        if (pluck_position == 8'd0)
        begin
            p_sat = IW'(1);
        end
        else if (13'(pluck_position) > 13'(NUM_MASSES - 2))
        begin
            p_sat = LAST_INT;
        end
        else
        begin
            p_sat = IW'(pluck_position);
        end
        if (subs_reg == 7'd0)
        begin
            lim = 7'd1;
        end
        else if (subs_reg > 7'd64)
        begin
            lim = 7'd64;
        end
        else
        begin
            lim = subs_reg;
        end
        cnt1 = 7'(count_reg) + 7'd1;
    end

    // Divider and pluck accumulator steps
    always_comb
    begin
        dv   = dsel_reg ? (MASSES_W - p_reg) : p_reg;
        rem2 = {rem_reg, PLUCK_PEAK[bit_reg]};
        ge   = (rem2 >= {1'b0, dv});
        seg  = (idx_reg > p_reg);
        dvc  = seg ? (MASSES_W - p_reg) : p_reg;
        r0c  = seg ? rb_reg : ra_reg;
        q0c  = seg ? qb_reg : qa_reg;
        rsum = {1'b0, r_reg} + {1'b0, r0c};
        carry = (rsum >= {1'b0, dvc});
        rn   = carry ? IW'(rsum - {1'b0, dvc}) : IW'(rsum);
        qn   = q_reg + q0c + QUO_W'(carry);
        pluck_val = seg ? DISP_W'(PLUCK_PEAK - qn) : DISP_W'(qn);
    end

    // Vibrator and interior results
    always_comb
    begin
        vib_val = vib_en_reg ? sat32(vib_shape_reg ? (prod_reg >>> 32) : (prod_reg >>> 30))
                             : '0;
        res_val = sat32(prod_reg + PROD_W'(s_reg));
    end

    // Select multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_VIB:
            begin
                if (ph_reg == 4'd0)
                begin
                    mul_a = 33'(SINE_TABLE_DEPTH);
                    mul_b = {1'b0, phase_reg};
                end
                else
                begin
                    mul_a = 33'(level_reg);
                    mul_b = vib_shape_reg ? {1'b0, phase_reg} : 33'(sine_reg);
                end
            end
            S_MASS:
            begin
                case (ph_reg)
                    4'd2:
                    begin
                        mul_a = 33'(c2_reg);
                        mul_b = 33'(yoo_reg);
                    end
                    4'd3:
                    begin
                        mul_a = {2'b0, c3_reg};
                        mul_b = {3'b0, lap_reg[29:0]};
                    end
                    4'd4:
                    begin
                        mul_a = {2'b0, c3_reg};
                        mul_b = 33'(signed'(lap_reg[34:30]));
                    end
                    4'd6:
                    begin
                        mul_a = {2'b0, c1_reg};
                        mul_b = {3'b0, inner_reg[29:0]};
                    end
                    4'd7:
                    begin
                        mul_a = {2'b0, c1_reg};
                        mul_b = 33'(signed'(inner_reg[37:30]));
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            S_OUT:
            begin
                mul_a = GAIN_30DB;
                mul_b = (ph_reg == 4'd0) ? 33'(left_y_reg) : 33'(right_y_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_full = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // Bank write and read addressing
    always_comb
    begin
        wr_en   = 3'b000;
        wr_addr = idx_reg;
        wr_data = res_val;
        ra_o    = '0;
        ra_oo   = '0;
        shift_en = 1'b0;
        case (state_reg)
            S_CLR:
            begin
                wr_en   = 3'b111;
                wr_data = '0;
            end
            S_VIB:
            begin
                if (ph_reg == 4'd3)
                begin
                    wr_en[yb] = 1'b1;
                    wr_addr   = '0;
                    wr_data   = vib_val;
                end
            end
            S_LOAD:
            begin
                ra_o     = (ph_reg == 4'd0) ? IW'(0) : IW'(1);
                shift_en = (ph_reg != 4'd0);
            end
            S_MASS:
            begin
                ra_o  = IW'(idx_reg + IW'(1));
                ra_oo = idx_reg;
                shift_en = (ph_reg == 4'd1);
                if (ph_reg == 4'd8)
                begin
                    wr_en[yb] = 1'b1;
                end
            end
            S_PLUCK:
            begin
                wr_en[ob] = 1'b1;
                wr_data   = pluck_val;
            end
            default:
            begin
                wr_en = 3'b000;
            end
        endcase
    end

    // Sequence commands
    always_comb
    begin
        state_next  = state_reg;
        ph_next     = ph_reg;
        idx_next    = idx_reg;
        rot_next    = rot_reg;
        phase_next  = phase_reg;
        count_next  = count_reg;
        emit_next   = emit_reg;
        strobe_next = 1'b0;
        dsel_next   = dsel_reg;
        bit_next    = bit_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ph_next = '0;
                    case (opcode)
                        OP_STEP:
                        begin
                            state_next = S_VIB;
                            emit_next  = (count_reg == 6'd0);
                            count_next = (cnt1 >= lim) ? 6'd0 : cnt1[5:0];
                        end
                        OP_PLUCK:
                        begin
                            state_next = S_DIV;
                            dsel_next  = 1'b0;
                            bit_next   = 5'(QUO_W - 1);
                        end
                        OP_CLEAR:
                        begin
                            state_next = S_CLR;
                            idx_next   = '0;
                            rot_next   = '0;
                            phase_next = '0;
                            count_next = '0;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CLR:
            begin
                idx_next = IW'(idx_reg + IW'(1));
                if (idx_reg == LAST_MASS)
                begin
                    state_next = S_IDLE;
                end
            end
            S_VIB:
            begin
                ph_next = ph_reg + 4'd1;
                if (ph_reg == 4'd3)
                begin
                    if (vib_en_reg)
                    begin
                        phase_next = phase_reg + inc_reg;
                    end
                    state_next = S_LOAD;
                    ph_next    = '0;
                end
            end
            S_LOAD:
            begin
                ph_next = ph_reg + 4'd1;
                if (ph_reg == 4'd2)
                begin
                    state_next = S_MASS;
                    ph_next    = '0;
                    idx_next   = IW'(1);
                end
            end
            S_MASS:
            begin
                ph_next = ph_reg + 4'd1;
                if (ph_reg == 4'd8)
                begin
                    ph_next  = '0;
                    idx_next = IW'(idx_reg + IW'(1));
                    if (idx_reg == LAST_INT)
                    begin
                        rot_next   = bank_dec(rot_reg);
                        state_next = emit_reg ? S_OUT : S_IDLE;
                    end
                end
            end
            S_OUT:
            begin
                ph_next = ph_reg + 4'd1;
                if (ph_reg == 4'd2)
                begin
                    strobe_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_DIV:
            begin
                bit_next = bit_reg - 5'd1;
                if (bit_reg == 5'd0)
                begin
                    bit_next  = 5'(QUO_W - 1);
                    dsel_next = 1'b1;
                    if (dsel_reg)
                    begin
                        state_next = S_PLUCK;
                        idx_next   = IW'(1);
                    end
                end
            end
            S_PLUCK:
            begin
                idx_next = IW'(idx_reg + IW'(1));
                if (idx_reg == LAST_INT)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLR;
            ph_reg     <= '0;
            idx_reg    <= '0;
            rot_reg    <= '0;
            phase_reg  <= '0;
            count_reg  <= '0;
            emit_reg   <= 1'b0;
            strobe_reg <= 1'b0;
            dsel_reg   <= 1'b0;
            bit_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ph_reg     <= ph_next;
            idx_reg    <= idx_next;
            rot_reg    <= rot_next;
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            emit_reg   <= emit_next;
            strobe_reg <= strobe_next;
            dsel_reg   <= dsel_next;
            bit_reg    <= bit_next;
        end
    end

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg        <= 31'd1073741824;
            c2_reg        <= 32'sd1073741824;
            c3_reg        <= 31'd1073741824;
            vib_en_reg    <= 1'b0;
            vib_shape_reg <= 1'b0;
            level_reg     <= 32'sd1073742;
            inc_reg       <= 32'd1217;
            subs_reg      <= 7'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DAMP_SCALE: c1_reg        <= cfg_data[30:0];
                CFG_PREV_DAMP:  c2_reg        <= cfg_data;
                CFG_COUPLING:   c3_reg        <= cfg_data[30:0];
                CFG_VIB_EN:     vib_en_reg    <= cfg_data[0];
                CFG_VIB_SHAPE:  vib_shape_reg <= cfg_data[0];
                CFG_VIB_LEVEL:  level_reg     <= cfg_data;
                CFG_PHASE_INC:  inc_reg       <= cfg_data;
                CFG_SUBSTEPS:   subs_reg      <= cfg_data[6:0];
                default:        subs_reg      <= subs_reg;
            endcase
        end
    end

    // Advance the datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_full;
        sine_reg <= SINE_ROM[prod_reg[32 +: SW]];
        if (shift_en)
        begin
            ym1_reg <= yc_reg;
            yc_reg  <= yp_reg;
            yp_reg  <= rd_o;
        end
        if (state_reg == S_MASS)
        begin
            case (ph_reg)
                4'd1: yoo_reg <= rd_oo;
                4'd2: lap_reg <= 35'(ym1_reg) + 35'(yp_reg) - (35'(yc_reg) <<< 1);
                4'd3: acc_reg <= 35'((PROD_W'(yc_reg) <<< 1) - (prod_reg >>> 30));
                4'd4: s_reg   <= 32'(prod_reg >>> 30);
                4'd5: inner_reg <= 38'(PROD_W'(acc_reg) + PROD_W'(s_reg) + prod_reg);
                4'd7: s_reg   <= 32'(prod_reg >>> 30);
                default: s_reg <= s_reg;
            endcase
        end
        // Capture pickup masses as they are written
        if (wr_en[yb] && (state_reg == S_VIB || state_reg == S_MASS))
        begin
            if (wr_addr == LEFT_PICK)
            begin
                left_y_reg <= wr_data;
            end
            if (wr_addr == RIGHT_PICK)
            begin
                right_y_reg <= wr_data;
            end
        end
        if (state_reg == S_OUT && ph_reg == 4'd1)
        begin
            left_out_reg <= sat24(prod_reg >>> 23);
        end
        if (state_reg == S_OUT && ph_reg == 4'd2)
        begin
            right_out_reg <= sat24(prod_reg >>> 23);
        end
        // Divide the pluck peak by each segment length, one bit a cycle
        if (state_reg == S_IDLE)
        begin
            p_reg   <= p_sat;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        if (state_reg == S_DIV)
        begin
            if (bit_reg == 5'd0)
            begin
                rem_reg <= '0;
                quo_reg <= '0;
                if (dsel_reg)
                begin
                    qb_reg <= {quo_reg[QUO_W-2:0], ge};
                    rb_reg <= ge ? IW'(rem2 - {1'b0, dv}) : IW'(rem2);
                end
                else
                begin
                    qa_reg <= {quo_reg[QUO_W-2:0], ge};
                    ra_reg <= ge ? IW'(rem2 - {1'b0, dv}) : IW'(rem2);
                end
            end
            else
            begin
                rem_reg <= ge ? IW'(rem2 - {1'b0, dv}) : IW'(rem2);
                quo_reg <= {quo_reg[QUO_W-2:0], ge};
            end
            q_reg <= '0;
            r_reg <= '0;
        end
        // Step the pluck ramp, restarting at the peak
        if (state_reg == S_PLUCK)
        begin
            if (idx_reg == p_reg)
            begin
                q_reg <= '0;
                r_reg <= '0;
            end
            else
            begin
                q_reg <= qn;
                r_reg <= rn;
            end
        end
    end

endmodule

FILE: design/swsim_checker.sv
// Port-level checks of the string wave simulator, bound to the top level.
module swsim_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   start,
    input logic                                   busy,
    input logic [1:0]                             opcode,
    input logic [7:0]                             pluck_position,
    input logic                                   cfg_valid,
    input logic                                   cfg_ready,
    input logic [swsim_pkg::CFG_IDX_W-1:0]        cfg_index,
    input logic [31:0]                            cfg_data,
    input logic                                   sample_strobe,
    input logic signed [swsim_pkg::SAMPLE_W-1:0]  left_sample,
    input logic signed [swsim_pkg::SAMPLE_W-1:0]  right_sample
);
    import swsim_pkg::*;

    // A sample ends a step, so the block was busy just before
    a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sample_strobe |-> $past(busy))
        else $error("sample strobe without a preceding busy step");

    // The sample is shown with the block already idle
    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        sample_strobe |-> !busy)
        else $error("sample strobe while busy");

    // One result per step: the strobe is a pulse and is never held
    a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        sample_strobe |=> !sample_strobe)
        else $error("sample strobe held for two cycles");

    // Every defined command keeps the block busy afterwards
    a_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (opcode == OP_STEP || opcode == OP_PLUCK || opcode == OP_CLEAR))
        |=> busy)
        else $error("accepted command did not raise busy");

endmodule

bind string_wave_simulator_unit swsim_checker u_swsim_checker (.*);
